FILE: hw/rtl/osft_pkg.sv
// Shared types and constants for the object slot table with free list.
// Holds transfer payload structs, operation and status codes, and the
// command and status structs between controller and datapath.
`default_nettype none

package osft_pkg;

    // Operation codes carried in the input transfer
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_NEXT   = 2'd2
    } t_op;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // Fixed field widths of the transfer payloads
    localparam int unsigned SLOT_IN_W  = 11;
    localparam int unsigned SLOT_OUT_W = 10;
    localparam int unsigned NEXT_W     = 11;
    localparam int unsigned HANDLE_W   = 64;

    typedef struct packed {
        logic [1:0]            operation;
        logic [HANDLE_W-1:0]   handle;
        logic [SLOT_IN_W-1:0]  slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            status;
        logic [SLOT_OUT_W-1:0] slot_out;
        logic [HANDLE_W-1:0]   handle_out;
        logic [NEXT_W-1:0]     next_slot;
    } t_out_item;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN
    } t_state;

    // Entry store write selection
    typedef enum logic [1:0] {
        EW_NONE,
        EW_FILL,
        EW_POP,
        EW_CLEAR
    } t_ent_wr;

    // Result selection
    typedef enum logic [2:0] {
        RES_ADD_FILL,
        RES_ADD_POP,
        RES_FULL,
        RES_IGNORED,
        RES_REM_OK,
        RES_OVERFLOW,
        RES_NONE,
        RES_HIT
    } t_res_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     capture;
        t_ent_wr  ent_wr;
        logic     ent_rd_next;
        logic     q_push;
        logic     q_pop;
        logic     fill_inc;
        logic     scan_load;
        logic     scan_adv;
        logic     res_load;
        t_res_sel res_sel;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic q_empty;
        logic q_full;
        logic tbl_full;
        logic slot_ge_fill;
        logic hit;
        logic scan_last;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/osft_dp.sv
// Datapath: entry store and free queue memories, fill mark, queue pointers,
// scan index and result register. Uses osft_pkg types and codes.
`default_nettype none

module osft_dp #(
    parameter int unsigned SLOT_COUNT = 1024
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  osft_pkg::t_in_item  i_item,
    input  osft_pkg::t_dp_cmd   i_cmd,
    output osft_pkg::t_dp_stat  o_stat,
    output osft_pkg::t_out_item o_result,
    output logic                o_done
);

    localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
    localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int unsigned CMP_W = (CNT_W > osft_pkg::SLOT_IN_W) ? CNT_W
                                                                  : osft_pkg::SLOT_IN_W;

    // Memories
    logic [osft_pkg::HANDLE_W-1:0] r_entry_mem [SLOT_COUNT];
    logic [IDX_W-1:0]              r_queue_mem [SLOT_COUNT];

    logic [osft_pkg::HANDLE_W-1:0] r_ent_rdata;
    logic [IDX_W-1:0]              r_q_rdata;

    // Control registers
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_done;

    // Payload registers
    logic [osft_pkg::HANDLE_W-1:0] r_handle;
    logic [IDX_W-1:0]              r_scan;
    osft_pkg::t_out_item           r_result, n_result;

    logic                          ent_we;
    logic [IDX_W-1:0]              ent_waddr;
    logic [osft_pkg::HANDLE_W-1:0] ent_wdata;
    logic [IDX_W-1:0]              ent_raddr;
    logic [IDX_W-1:0]              in_idx;
    logic [IDX_W-1:0]              scan_inc;
    logic [CNT_W-1:0]              scan_nxt_cnt;

    assign in_idx       = IDX_W'(i_item.slot);
    assign scan_inc     = r_scan + IDX_W'(1);
    assign scan_nxt_cnt = CNT_W'(r_scan) + CNT_W'(1);

    // Status toward the controller
    assign o_stat.q_empty      = (r_count == '0);
    assign o_stat.q_full       = (r_count == CNT_W'(SLOT_COUNT));
    assign o_stat.tbl_full     = (r_fill == CNT_W'(SLOT_COUNT));
    assign o_stat.slot_ge_fill = (CMP_W'(i_item.slot) >= CMP_W'(r_fill));
    assign o_stat.hit          = (r_ent_rdata != '0);
    assign o_stat.scan_last    = (scan_nxt_cnt >= r_fill);

    // Select entry store write port
    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = in_idx;
        ent_wdata = '0;
        unique case (i_cmd.ent_wr)
            osft_pkg::EW_NONE: begin
                ent_we = 1'b0;
            end
            osft_pkg::EW_FILL: begin
                ent_we    = 1'b1;
                ent_waddr = r_fill[IDX_W-1:0];
                ent_wdata = i_item.handle;
            end
            osft_pkg::EW_POP: begin
                ent_we    = 1'b1;
                ent_waddr = r_q_rdata;
                ent_wdata = r_handle;
            end
            osft_pkg::EW_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = in_idx;
                ent_wdata = '0;
            end
            default: begin
                ent_we = 1'b0;
            end
        endcase
    end

    assign ent_raddr = i_cmd.ent_rd_next ? scan_inc : in_idx;

    // Entry store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_entry_mem[ent_waddr] <= ent_wdata;
        end
        r_ent_rdata <= r_entry_mem[ent_raddr];
    end

    // Free queue: push at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_push) begin
            r_queue_mem[r_tail] <= in_idx;
        end
        r_q_rdata <= r_queue_mem[r_head];
    end

    // Advance fill mark and queue pointers
    always_comb begin
        n_fill  = r_fill;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.fill_inc) begin
            n_fill = r_fill + CNT_W'(1);
        end
        if (i_cmd.q_pop) begin
            n_head  = (r_head == IDX_W'(SLOT_COUNT - 1)) ? '0 : r_head + IDX_W'(1);
            n_count = r_count - CNT_W'(1);
        end else if (i_cmd.q_push) begin
            n_tail  = (r_tail == IDX_W'(SLOT_COUNT - 1)) ? '0 : r_tail + IDX_W'(1);
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_done  <= i_cmd.res_load;
        end
    end

    // Hold handle for a queued add and step the scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_handle <= i_item.handle;
        end
        if (i_cmd.scan_load) begin
            r_scan <= in_idx;
        end else if (i_cmd.scan_adv) begin
            r_scan <= scan_inc;
        end
    end

    // Build the result
    always_comb begin
        n_result            = '0;
        n_result.status     = osft_pkg::ST_OK;
        unique case (i_cmd.res_sel)
            osft_pkg::RES_ADD_FILL: begin
                n_result.slot_out = osft_pkg::SLOT_OUT_W'(r_fill);
            end
            osft_pkg::RES_ADD_POP: begin
                n_result.slot_out = osft_pkg::SLOT_OUT_W'(r_q_rdata);
            end
            osft_pkg::RES_FULL: begin
                n_result.status = osft_pkg::ST_FULL;
            end
            osft_pkg::RES_IGNORED: begin
                n_result.status = osft_pkg::ST_IGNORED;
            end
            osft_pkg::RES_REM_OK: begin
                n_result.status = osft_pkg::ST_OK;
            end
            osft_pkg::RES_OVERFLOW: begin
                n_result.status = osft_pkg::ST_OVERFLOW;
            end
            osft_pkg::RES_NONE: begin
                n_result.status    = osft_pkg::ST_NONE;
                n_result.next_slot = osft_pkg::NEXT_W'(r_fill);
            end
            osft_pkg::RES_HIT: begin
                n_result.handle_out = r_ent_rdata;
                n_result.next_slot  = osft_pkg::NEXT_W'(scan_nxt_cnt);
            end
            default: begin
                n_result.status = osft_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

`default_nettype wire

FILE: hw/rtl/osft_ctrl.sv
// Controller state machine: decodes operations and sequences the datapath.
// Uses osft_pkg command, status and state types.
`default_nettype none

module osft_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire [1:0]          i_op,
    input  osft_pkg::t_dp_stat i_stat,
    output osft_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    osft_pkg::t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= osft_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != osft_pkg::S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.ent_wr  = osft_pkg::EW_NONE;
        o_cmd.res_sel = osft_pkg::RES_REM_OK;
        unique case (r_state)
            osft_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_op)
                        osft_pkg::OP_ADD: begin
                            if (!i_stat.q_empty) begin
                                // reuse the oldest freed slot
                                o_cmd.q_pop = 1'b1;
                                n_state     = osft_pkg::S_POP;
                            end else if (!i_stat.tbl_full) begin
                                o_cmd.ent_wr   = osft_pkg::EW_FILL;
                                o_cmd.fill_inc = 1'b1;
                                o_cmd.res_load = 1'b1;
                                o_cmd.res_sel  = osft_pkg::RES_ADD_FILL;
                            end else begin
                                o_cmd.res_load = 1'b1;
                                o_cmd.res_sel  = osft_pkg::RES_FULL;
                            end
                        end
                        osft_pkg::OP_REMOVE: begin
                            o_cmd.res_load = 1'b1;
                            if (i_stat.slot_ge_fill) begin
                                o_cmd.res_sel = osft_pkg::RES_IGNORED;
                            end else if (i_stat.q_full) begin
                                // clear but drop the queue push
                                o_cmd.ent_wr  = osft_pkg::EW_CLEAR;
                                o_cmd.res_sel = osft_pkg::RES_OVERFLOW;
                            end else begin
                                o_cmd.ent_wr  = osft_pkg::EW_CLEAR;
                                o_cmd.q_push  = 1'b1;
                                o_cmd.res_sel = osft_pkg::RES_REM_OK;
                            end
                        end
                        osft_pkg::OP_NEXT: begin
                            if (i_stat.slot_ge_fill) begin
                                o_cmd.res_load = 1'b1;
                                o_cmd.res_sel  = osft_pkg::RES_NONE;
                            end else begin
                                o_cmd.scan_load = 1'b1;
                                n_state         = osft_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            // unused code: no result, no change
                            o_cmd.capture = 1'b1;
                        end
                    endcase
                end
            end
            osft_pkg::S_POP: begin
                o_cmd.ent_wr   = osft_pkg::EW_POP;
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = osft_pkg::RES_ADD_POP;
                n_state        = osft_pkg::S_IDLE;
            end
            osft_pkg::S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = osft_pkg::RES_HIT;
                    n_state        = osft_pkg::S_IDLE;
                end else if (i_stat.scan_last) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = osft_pkg::RES_NONE;
                    n_state        = osft_pkg::S_IDLE;
                end else begin
                    // fetch the following entry
                    o_cmd.scan_adv    = 1'b1;
                    o_cmd.ent_rd_next = 1'b1;
                end
            end
            default: begin
                n_state = osft_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/object_slot_table_free_list_core.sv
// Top level of the object slot table with free list.
// Instantiates osft_ctrl and osft_dp; uses osft_pkg payload types.
`default_nettype none

// Usage:
//   Input channel: drive i_item and raise start; the transfer happens at a
//   rising edge with start high and busy low. Operations: add a handle,
//   remove a slot, find the next occupied slot from a start slot.
//   Result channel: o_result is valid for exactly one cycle with o_done high.
//   Every operation except the unused code gives one result, in order.
// Sequencing:
//   Add into a fresh slot, remove, and a next whose start lies at or beyond
//   the fill mark: result in the cycle after the transfer, busy stays low,
//   one item per cycle.
//   Add that reuses a freed slot: an extra state with busy high for the free
//   queue read, then the result is registered.
//   Next: busy stays high while the scan reads the entries one by one through
//   the single read port of the entry store, then the result is registered.
// Reset: synchronous, active low; empties the table and the free queue.
//   No clearing pass is needed. The receiver cannot stall the results.

module object_slot_table_free_list_core #(
    parameter int unsigned SLOT_COUNT = 1024
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  osft_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_done,
    output osft_pkg::t_out_item o_result
);

    osft_pkg::t_dp_cmd  dp_cmd;
    osft_pkg::t_dp_stat dp_stat;

    osft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.operation),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    osft_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule

`default_nettype wire
